[rtl/scbb_pkg.sv]
// Shared types, constants and command codes of the scene bounding box block.
package scbb_pkg;

	// Table sizes.
	localparam int MAX_SPHERES   = 256;
	localparam int MAX_CYLINDERS = 256;

	// Address and count widths follow from the table sizes.
	localparam int SPH_AW    = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
	localparam int CYL_AW    = (MAX_CYLINDERS > 1) ? $clog2(MAX_CYLINDERS) : 1;
	localparam int SPH_CNT_W = $clog2(MAX_SPHERES + 1);
	localparam int CYL_CNT_W = $clog2(MAX_CYLINDERS + 1);
	localparam int WALK_W    = (SPH_AW > CYL_AW) ? SPH_AW : CYL_AW;
	localparam int CMP_W     = (SPH_CNT_W > CYL_CNT_W) ? SPH_CNT_W : CYL_CNT_W;

	// Field widths.
	localparam int COORD_W = 32;
	localparam int RAD_W   = 31;
	localparam int IDX_W   = 16;
	localparam int AXES    = 3;
	localparam int IXW     = (IDX_W > SPH_CNT_W) ? IDX_W + 1 : SPH_CNT_W + 1;

	// Command codes.
	localparam logic [1:0] CMD_ADD_SPHERE   = 2'd0;
	localparam logic [1:0] CMD_ADD_CYLINDER = 2'd1;
	localparam logic [1:0] CMD_CLEAR        = 2'd2;
	localparam logic [1:0] CMD_QUERY        = 2'd3;

	// Saturation limits of a signed Q16.16 coordinate.
	localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef logic [COORD_W-1:0] coord_t;

	// One entry of the sphere memory.
	typedef struct packed {
		coord_t [AXES-1:0] c;
		logic [RAD_W-1:0]  rad;
	} sphere_t;

	// One entry of the cylinder memory.
	typedef struct packed {
		logic [RAD_W-1:0] rad;
		logic [IDX_W-1:0] b;
		logic [IDX_W-1:0] a;
	} cyl_t;

	// Control from the table walker to the extent datapath.
	typedef struct packed {
		logic              issue;
		logic              issue_sph;
		logic [WALK_W-1:0] idx;
		logic              init;
		logic              finish;
	} walk_ctrl_t;

	// One query result.
	typedef struct packed {
		coord_t [AXES-1:0] lo;
		coord_t [AXES-1:0] hi;
		coord_t [AXES-1:0] mid;
		logic              empty;
		logic              overflow;
	} box_t;

endpackage

[rtl/sphere_cylinder_bounding_box.sv]
// Adds and clears may be transferred back to back.
// A query holds busy while it walks the sphere and cylinder tables and while the extent
// pipeline drains, also on an empty scene.
// The result strobe done is high in the same cycle in which busy falls; the receiver cannot stall.
// The walk reads one table entry a cycle through the sphere and cylinder memories.
// Reset clears both counts and the overflow flag; memory contents are kept.
module sphere_cylinder_bounding_box (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        command,
	input  logic signed [31:0]                pos_x,
	input  logic signed [31:0]                pos_y,
	input  logic signed [31:0]                pos_z,
	input  logic [30:0]                       rad,
	input  logic [15:0]                       end_a_index,
	input  logic [15:0]                       end_b_index,
	output logic                              done,
	output logic signed [31:0]                low_x,
	output logic signed [31:0]                low_y,
	output logic signed [31:0]                low_z,
	output logic signed [31:0]                high_x,
	output logic signed [31:0]                high_y,
	output logic signed [31:0]                high_z,
	output logic signed [31:0]                mid_x,
	output logic signed [31:0]                mid_y,
	output logic signed [31:0]                mid_z,
	output logic                              scene_empty,
	output logic                              table_overflow
);

	logic                           accept;
	logic [scbb_pkg::SPH_CNT_W-1:0] sph_total_q;
	logic [scbb_pkg::CYL_CNT_W-1:0] cyl_total_q;
	logic                           overflow_q;
	logic                           sph_full;
	logic                           cyl_full;
	logic                           sph_we;
	logic                           cyl_we;
	scbb_pkg::sphere_t              sph_wdata;
	scbb_pkg::cyl_t                 cyl_wdata;
	scbb_pkg::sphere_t              sph_rdata_a;
	scbb_pkg::sphere_t              sph_rdata_b;
	scbb_pkg::cyl_t                 cyl_rdata;
	logic [scbb_pkg::SPH_AW-1:0]    sph_raddr_a;
	logic [scbb_pkg::SPH_AW-1:0]    sph_raddr_b;
	scbb_pkg::walk_ctrl_t           ctrl;
	logic                           pipe_busy;
	scbb_pkg::box_t                 result;

	// Command transfer and table writes.
	assign accept   = start && !busy;
	assign sph_full = !(sph_total_q < scbb_pkg::SPH_CNT_W'(scbb_pkg::MAX_SPHERES));
	assign cyl_full = !(cyl_total_q < scbb_pkg::CYL_CNT_W'(scbb_pkg::MAX_CYLINDERS));
	assign sph_we   = accept && (command == scbb_pkg::CMD_ADD_SPHERE) && !sph_full;
	assign cyl_we   = accept && (command == scbb_pkg::CMD_ADD_CYLINDER) && !cyl_full;

	always_comb begin
		sph_wdata.c[0] = pos_x;
		sph_wdata.c[1] = pos_y;
		sph_wdata.c[2] = pos_z;
		sph_wdata.rad  = rad;
		cyl_wdata.a    = end_a_index;
		cyl_wdata.b    = end_b_index;
		cyl_wdata.rad  = rad;
	end

	// Fill counts and the sticky overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sph_total_q <= '0;
			cyl_total_q <= '0;
			overflow_q  <= 1'b0;
		end else if (accept) begin
			unique case (command)
				scbb_pkg::CMD_ADD_SPHERE: begin
					if (sph_full) begin
						overflow_q <= 1'b1;
					end else begin
						sph_total_q <= sph_total_q + scbb_pkg::SPH_CNT_W'(1);
					end
				end
				scbb_pkg::CMD_ADD_CYLINDER: begin
					if (cyl_full) begin
						overflow_q <= 1'b1;
					end else begin
						cyl_total_q <= cyl_total_q + scbb_pkg::CYL_CNT_W'(1);
					end
				end
				scbb_pkg::CMD_CLEAR: begin
					sph_total_q <= '0;
					cyl_total_q <= '0;
					overflow_q  <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Sphere memory, held in two copies so that both cylinder ends read at once.
	scbb_ram #(
		.WIDTH ($bits(scbb_pkg::sphere_t)),
		.DEPTH (scbb_pkg::MAX_SPHERES)
	) u_sph_ram_a (
		.clk   (clk),
		.we    (sph_we),
		.waddr (sph_total_q[scbb_pkg::SPH_AW-1:0]),
		.wdata (sph_wdata),
		.raddr (sph_raddr_a),
		.rdata (sph_rdata_a)
	);

	scbb_ram #(
		.WIDTH ($bits(scbb_pkg::sphere_t)),
		.DEPTH (scbb_pkg::MAX_SPHERES)
	) u_sph_ram_b (
		.clk   (clk),
		.we    (sph_we),
		.waddr (sph_total_q[scbb_pkg::SPH_AW-1:0]),
		.wdata (sph_wdata),
		.raddr (sph_raddr_b),
		.rdata (sph_rdata_b)
	);

	// Cylinder memory.
	scbb_ram #(
		.WIDTH ($bits(scbb_pkg::cyl_t)),
		.DEPTH (scbb_pkg::MAX_CYLINDERS)
	) u_cyl_ram (
		.clk   (clk),
		.we    (cyl_we),
		.waddr (cyl_total_q[scbb_pkg::CYL_AW-1:0]),
		.wdata (cyl_wdata),
		.raddr (ctrl.idx[scbb_pkg::CYL_AW-1:0]),
		.rdata (cyl_rdata)
	);

	// Query walk.
	scbb_walk u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start_query (accept && (command == scbb_pkg::CMD_QUERY)),
		.sph_total   (sph_total_q),
		.cyl_total   (cyl_total_q),
		.pipe_busy   (pipe_busy),
		.ctrl        (ctrl),
		.busy        (busy)
	);

	// Box datapath.
	scbb_extent u_extent (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.sph_total    (sph_total_q),
		.cyl_total    (cyl_total_q),
		.overflow     (overflow_q),
		.cyl_rdata    (cyl_rdata),
		.sph_rdata_a  (sph_rdata_a),
		.sph_rdata_b  (sph_rdata_b),
		.sph_raddr_a  (sph_raddr_a),
		.sph_raddr_b  (sph_raddr_b),
		.pipe_busy    (pipe_busy),
		.result       (result),
		.result_valid (done)
	);

	// Result ports.
	assign low_x          = result.lo[0];
	assign low_y          = result.lo[1];
	assign low_z          = result.lo[2];
	assign high_x         = result.hi[0];
	assign high_y         = result.hi[1];
	assign high_z         = result.hi[2];
	assign mid_x          = result.mid[0];
	assign mid_y          = result.mid[1];
	assign mid_z          = result.mid[2];
	assign scene_empty    = result.empty;
	assign table_overflow = result.overflow;

	// A query transfer always starts a walk.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command == scbb_pkg::CMD_QUERY)) |=> busy)
		else $error("query transfer did not start a walk");

	// The result strobe comes at the end of a walk.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe outside the end of a walk");

	// The tables are never written while a walk reads them.
	assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !sph_we && !cyl_we)
		else $error("table write during a walk");

endmodule

[rtl/scbb_ram.sv]
// Simple dual-port memory: one write port and one read port with registered data.
module scbb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/scbb_walk.sv]
// Walker: steps through the sphere table, then the cylinder table, then waits for
// the extent pipeline to empty before it releases the result.
module scbb_walk (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start_query,
	input  logic [scbb_pkg::SPH_CNT_W-1:0] sph_total,
	input  logic [scbb_pkg::CYL_CNT_W-1:0] cyl_total,
	input  logic                           pipe_busy,
	output scbb_pkg::walk_ctrl_t           ctrl,
	output logic                           busy
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SPH   = 2'd1;
	localparam logic [1:0] ST_CYL   = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [1:0]                    state_q;
	logic [scbb_pkg::WALK_W-1:0]   idx_q;
	logic                          sph_last;
	logic                          cyl_last;

	// The last entry of each table ends its phase.
	assign sph_last = scbb_pkg::CMP_W'(idx_q)
		== scbb_pkg::CMP_W'(sph_total) - scbb_pkg::CMP_W'(1);
	assign cyl_last = scbb_pkg::CMP_W'(idx_q)
		== scbb_pkg::CMP_W'(cyl_total) - scbb_pkg::CMP_W'(1);

	// Phase sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (start_query) begin
						if (sph_total != '0) begin
							state_q <= ST_SPH;
						end else if (cyl_total != '0) begin
							state_q <= ST_CYL;
						end else begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_SPH: begin
					if (sph_last) begin
						idx_q   <= '0;
						state_q <= (cyl_total != '0) ? ST_CYL : ST_DRAIN;
					end else begin
						idx_q <= idx_q + scbb_pkg::WALK_W'(1);
					end
				end
				ST_CYL: begin
					if (cyl_last) begin
						idx_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + scbb_pkg::WALK_W'(1);
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Control towards the datapath.
	always_comb begin
		ctrl.issue     = (state_q == ST_SPH) || (state_q == ST_CYL);
		ctrl.issue_sph = (state_q == ST_SPH);
		ctrl.idx       = idx_q;
		ctrl.init      = start_query;
		ctrl.finish    = (state_q == ST_DRAIN) && !pipe_busy;
	end

	assign busy = (state_q != ST_IDLE);

endmodule

[rtl/scbb_extent.sv]
// Extent datapath: resolves cylinder ends, forms the min/max per entry with
// saturation and folds it into the running box. Four register stages.
module scbb_extent (
	input  logic                           clk,
	input  logic                           arst_n,
	input  scbb_pkg::walk_ctrl_t           ctrl,
	input  logic [scbb_pkg::SPH_CNT_W-1:0] sph_total,
	input  logic [scbb_pkg::CYL_CNT_W-1:0] cyl_total,
	input  logic                           overflow,
	input  scbb_pkg::cyl_t                 cyl_rdata,
	input  scbb_pkg::sphere_t              sph_rdata_a,
	input  scbb_pkg::sphere_t              sph_rdata_b,
	output logic [scbb_pkg::SPH_AW-1:0]    sph_raddr_a,
	output logic [scbb_pkg::SPH_AW-1:0]    sph_raddr_b,
	output logic                           pipe_busy,
	output scbb_pkg::box_t                 result,
	output logic                           result_valid
);

	localparam int AXES = scbb_pkg::AXES;
	localparam int CW   = scbb_pkg::COORD_W;

	logic                          valid_s1;
	logic                          sph_s1;
	logic [scbb_pkg::WALK_W-1:0]   idx_s1;
	logic                          cyl_ok;

	logic                          valid_s2;
	logic                          sph_s2;
	logic [scbb_pkg::RAD_W-1:0]    rad_s2;
	scbb_pkg::coord_t [AXES-1:0]   mn_d;
	scbb_pkg::coord_t [AXES-1:0]   mx_d;
	logic [scbb_pkg::RAD_W-1:0]    rad_d;

	logic                          valid_s3;
	scbb_pkg::coord_t [AXES-1:0]   mn_s3;
	scbb_pkg::coord_t [AXES-1:0]   mx_s3;
	logic [scbb_pkg::RAD_W-1:0]    rad_s3;
	scbb_pkg::coord_t [AXES-1:0]   l_d;
	scbb_pkg::coord_t [AXES-1:0]   h_d;
	logic [AXES-1:0][CW:0]         dl;
	logic [AXES-1:0][CW:0]         dh;

	logic                          valid_s4;
	scbb_pkg::coord_t [AXES-1:0]   l_s4;
	scbb_pkg::coord_t [AXES-1:0]   h_s4;

	scbb_pkg::coord_t [AXES-1:0]   lo_q;
	scbb_pkg::coord_t [AXES-1:0]   hi_q;
	logic [AXES-1:0][CW:0]         sum_d;
	logic                          empty_d;

	// Stage 1: cylinder entry is out of memory; pick the sphere read addresses.
	always_comb begin
		cyl_ok = (scbb_pkg::IXW'(cyl_rdata.a) < scbb_pkg::IXW'(sph_total))
			&& (scbb_pkg::IXW'(cyl_rdata.b) < scbb_pkg::IXW'(sph_total));
		if (sph_s1) begin
			sph_raddr_a = idx_s1[scbb_pkg::SPH_AW-1:0];
			sph_raddr_b = idx_s1[scbb_pkg::SPH_AW-1:0];
		end else begin
			sph_raddr_a = cyl_rdata.a[scbb_pkg::SPH_AW-1:0];
			sph_raddr_b = cyl_rdata.b[scbb_pkg::SPH_AW-1:0];
		end
	end

	// Stage 2: end centres are out of memory; order them per axis.
	always_comb begin
		for (int k = 0; k < AXES; k++) begin
			if ($signed(sph_rdata_a.c[k]) < $signed(sph_rdata_b.c[k])) begin
				mn_d[k] = sph_rdata_a.c[k];
				mx_d[k] = sph_rdata_b.c[k];
			end else begin
				mn_d[k] = sph_rdata_b.c[k];
				mx_d[k] = sph_rdata_a.c[k];
			end
		end
		rad_d = sph_s2 ? sph_rdata_a.rad : rad_s2;
	end

	// Stage 3: subtract and add the radius with saturation.
	always_comb begin
		for (int k = 0; k < AXES; k++) begin
			dl[k] = {mn_s3[k][CW-1], mn_s3[k]} - {2'b00, rad_s3};
			dh[k] = {mx_s3[k][CW-1], mx_s3[k]} + {2'b00, rad_s3};
			l_d[k] = (dl[k][CW] != dl[k][CW-1]) ? scbb_pkg::COORD_MIN : dl[k][CW-1:0];
			h_d[k] = (dh[k][CW] != dh[k][CW-1]) ? scbb_pkg::COORD_MAX : dh[k][CW-1:0];
		end
	end

	// Pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= ctrl.issue;
			valid_s2 <= valid_s1 && (sph_s1 || cyl_ok);
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		sph_s1 <= ctrl.issue_sph;
		idx_s1 <= ctrl.idx;
		sph_s2 <= sph_s1;
		rad_s2 <= cyl_rdata.rad;
		mn_s3  <= mn_d;
		mx_s3  <= mx_d;
		rad_s3 <= rad_d;
		l_s4   <= l_d;
		h_s4   <= h_d;
	end

	// Running box, started afresh on each query transfer.
	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			for (int k = 0; k < AXES; k++) begin
				lo_q[k] <= scbb_pkg::COORD_MAX;
				hi_q[k] <= scbb_pkg::COORD_MIN;
			end
		end else if (valid_s4) begin
			for (int k = 0; k < AXES; k++) begin
				if ($signed(l_s4[k]) < $signed(lo_q[k])) begin
					lo_q[k] <= l_s4[k];
				end
				if ($signed(h_s4[k]) > $signed(hi_q[k])) begin
					hi_q[k] <= h_s4[k];
				end
			end
		end
	end

	assign pipe_busy = valid_s1 || valid_s2 || valid_s3 || valid_s4;

	// Result forming: an empty scene gives zeros; the centre is the floored half sum.
	always_comb begin
		empty_d = (sph_total == '0) && (cyl_total == '0);
		for (int k = 0; k < AXES; k++) begin
			sum_d[k] = {lo_q[k][CW-1], lo_q[k]} + {hi_q[k][CW-1], hi_q[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			for (int k = 0; k < AXES; k++) begin
				result.lo[k]  <= empty_d ? '0 : lo_q[k];
				result.hi[k]  <= empty_d ? '0 : hi_q[k];
				result.mid[k] <= empty_d ? '0 : sum_d[k][CW:1];
			end
			result.empty    <= empty_d;
			result.overflow <= overflow;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= ctrl.finish;
		end
	end

	// The result is released only once every entry has been folded in.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.finish |-> !valid_s4 && !valid_s3)
		else $error("result released while the pipeline still holds entries");

	// A stage-two entry always stems from a stage-one entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $past(valid_s1))
		else $error("stage two entry without a stage one entry");

endmodule

[tb/sv/box_checker.sv]
// Watches the command and result channels of the bounding box block, keeps its
// own copy of the scene and compares every query result with the predicted box.
module scene_box_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         command,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [30:0]        rad,
	input  logic [15:0]        end_a_index,
	input  logic [15:0]        end_b_index,
	input  logic               done,
	input  logic signed [31:0] low_x,
	input  logic signed [31:0] low_y,
	input  logic signed [31:0] low_z,
	input  logic signed [31:0] high_x,
	input  logic signed [31:0] high_y,
	input  logic signed [31:0] high_z,
	input  logic signed [31:0] mid_x,
	input  logic signed [31:0] mid_y,
	input  logic signed [31:0] mid_z,
	input  logic               scene_empty,
	input  logic               table_overflow,
	output int                 mismatches,
	output int                 boxes_due
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the scene tables.
	scbb_pkg::coord_t           sph_pos [scbb_pkg::MAX_SPHERES][scbb_pkg::AXES];
	logic [scbb_pkg::RAD_W-1:0] sph_rad [scbb_pkg::MAX_SPHERES];
	scbb_pkg::cyl_t             cyl_tab [scbb_pkg::MAX_CYLINDERS];
	int unsigned                n_sph;
	int unsigned                n_cyl;
	bit                         ovf;

	// Boxes predicted for accepted queries, oldest first.
	scbb_pkg::box_t pending_boxes [$];

	string axis_tag [scbb_pkg::AXES] = '{"x", "y", "z"};

	// Saturates a sum to the signed 32-bit range.
	function automatic longint clamp(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint as_long(scbb_pkg::coord_t c);
		return longint'($signed(c));
	endfunction

	// Axis-aligned box over every stored sphere and every cylinder whose ends exist.
	function automatic scbb_pkg::box_t scene_extent();
		longint         lo [scbb_pkg::AXES];
		longint         hi [scbb_pkg::AXES];
		longint         va, vb, mn, mx, r, l, h;
		scbb_pkg::cyl_t cyl;
		scbb_pkg::box_t box;
		for (int k = 0; k < scbb_pkg::AXES; k++) begin
			lo[k] = 64'sd2147483647;
			hi[k] = -64'sd2147483648;
		end
		for (int unsigned i = 0; i < n_sph; i++) begin
			r = sph_rad[i];
			for (int k = 0; k < scbb_pkg::AXES; k++) begin
				va = as_long(sph_pos[i][k]);
				l = clamp(va - r);
				h = clamp(va + r);
				if (l < lo[k])
					lo[k] = l;
				if (h > hi[k])
					hi[k] = h;
			end
		end
		for (int unsigned i = 0; i < n_cyl; i++) begin
			cyl = cyl_tab[i];
			if (cyl.a < n_sph && cyl.b < n_sph) begin
				r = cyl.rad;
				for (int k = 0; k < scbb_pkg::AXES; k++) begin
					va = as_long(sph_pos[cyl.a][k]);
					vb = as_long(sph_pos[cyl.b][k]);
					mn = (va < vb) ? va : vb;
					mx = (va < vb) ? vb : va;
					l = clamp(mn - r);
					h = clamp(mx + r);
					if (l < lo[k])
						lo[k] = l;
					if (h > hi[k])
						hi[k] = h;
				end
			end
		end
		// An empty scene reports an all-zero box.
		if (n_sph == 0 && n_cyl == 0) begin
			for (int k = 0; k < scbb_pkg::AXES; k++) begin
				lo[k] = 0;
				hi[k] = 0;
			end
		end
		for (int k = 0; k < scbb_pkg::AXES; k++) begin
			box.lo[k]  = scbb_pkg::coord_t'(lo[k]);
			box.hi[k]  = scbb_pkg::coord_t'(hi[k]);
			box.mid[k] = scbb_pkg::coord_t'((lo[k] + hi[k]) >>> 1);
		end
		box.empty    = (n_sph == 0 && n_cyl == 0);
		box.overflow = ovf;
		return box;
	endfunction

	task automatic report(string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatches = mismatches + 1;
	endtask

	function automatic scbb_pkg::box_t observed_box();
		scbb_pkg::box_t box;
		box.lo[0]    = low_x;
		box.lo[1]    = low_y;
		box.lo[2]    = low_z;
		box.hi[0]    = high_x;
		box.hi[1]    = high_y;
		box.hi[2]    = high_z;
		box.mid[0]   = mid_x;
		box.mid[1]   = mid_y;
		box.mid[2]   = mid_z;
		box.empty    = scene_empty;
		box.overflow = table_overflow;
		return box;
	endfunction

	// Results are checked before the command of the same edge updates the scene.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_sph = 0;
			n_cyl = 0;
			ovf = 1'b0;
			pending_boxes.delete();
			mismatches = 0;
			boxes_due <= 0;
		end else begin
			if (done) begin
				if (pending_boxes.size() == 0) begin
					report("result strobe with no query outstanding");
				end else begin
					scbb_pkg::box_t want;
					scbb_pkg::box_t got;
					want = pending_boxes.pop_front();
					got = observed_box();
					for (int k = 0; k < scbb_pkg::AXES; k++) begin
						if (got.lo[k] !== want.lo[k])
							report($sformatf("low_%s got %h want %h",
								axis_tag[k], got.lo[k], want.lo[k]));
						if (got.hi[k] !== want.hi[k])
							report($sformatf("high_%s got %h want %h",
								axis_tag[k], got.hi[k], want.hi[k]));
						if (got.mid[k] !== want.mid[k])
							report($sformatf("mid_%s got %h want %h",
								axis_tag[k], got.mid[k], want.mid[k]));
					end
					if (got.empty !== want.empty)
						report($sformatf("scene_empty got %b want %b",
							got.empty, want.empty));
					if (got.overflow !== want.overflow)
						report($sformatf("table_overflow got %b want %b",
							got.overflow, want.overflow));
				end
			end
			// Command transfer.
			if (start && !busy) begin
				case (command)
					scbb_pkg::CMD_ADD_SPHERE: begin
						if (n_sph < scbb_pkg::MAX_SPHERES) begin
							sph_pos[n_sph][0] = pos_x;
							sph_pos[n_sph][1] = pos_y;
							sph_pos[n_sph][2] = pos_z;
							sph_rad[n_sph] = rad;
							n_sph = n_sph + 1;
						end else begin
							ovf = 1'b1;
						end
					end
					scbb_pkg::CMD_ADD_CYLINDER: begin
						if (n_cyl < scbb_pkg::MAX_CYLINDERS) begin
							cyl_tab[n_cyl] = '{rad: rad, b: end_b_index, a: end_a_index};
							n_cyl = n_cyl + 1;
						end else begin
							ovf = 1'b1;
						end
					end
					scbb_pkg::CMD_CLEAR: begin
						n_sph = 0;
						n_cyl = 0;
						ovf = 1'b0;
					end
					scbb_pkg::CMD_QUERY: begin
						pending_boxes = {pending_boxes, scene_extent()};
					end
				endcase
			end
			boxes_due <= pending_boxes.size();
		end
	end

endmodule

[tb/sv/testbench.sv]
// Top of the bounding box testbench: clock, reset, command stimulus and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1800;
	localparam int CALM_ITEMS   = 200;
	localparam int SETTLE       = 600;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         command;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic [30:0]        rad;
	logic [15:0]        end_a_index;
	logic [15:0]        end_b_index;
	logic               done;
	logic signed [31:0] low_x;
	logic signed [31:0] low_y;
	logic signed [31:0] low_z;
	logic signed [31:0] high_x;
	logic signed [31:0] high_y;
	logic signed [31:0] high_z;
	logic signed [31:0] mid_x;
	logic signed [31:0] mid_y;
	logic signed [31:0] mid_z;
	logic               scene_empty;
	logic               table_overflow;
	int                 mismatches;
	int                 boxes_due;

	// Stimulus bookkeeping: transfers so far and spheres in the current scene.
	int  items;
	int  item_goal;
	int  scene_spheres;
	bit  idling;

	sphere_cylinder_bounding_box DUT (.*);

	scene_box_checker box_check (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#(20_000_000);
		$display("testbench failed");
		$finish;
	end

	// Drives one command and waits for its transfer.
	task automatic issue(input logic [1:0] cmd, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [30:0] r, input logic [15:0] a,
			input logic [15:0] b);
		start <= 1'b1;
		command <= cmd;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		rad <= r;
		end_a_index <= a;
		end_b_index <= b;
		do
			@(posedge clk);
		while (busy);
		items++;
		if (cmd == scbb_pkg::CMD_ADD_SPHERE && scene_spheres < scbb_pkg::MAX_SPHERES)
			scene_spheres++;
		if (cmd == scbb_pkg::CMD_CLEAR)
			scene_spheres = 0;
	endtask

	// Clear and query carry random content on the unused fields.
	task automatic issue_cmd(input logic [1:0] cmd);
		issue(cmd, $urandom, $urandom, $urandom, 31'($urandom), 16'($urandom),
			16'($urandom));
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom;
			default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
		endcase
	endfunction

	function automatic logic [30:0] rand_rad();
		case ($urandom_range(0, 9))
			0: return 31'd0;
			1: return 31'h7FFF_FFFF;
			2, 3: return 31'($urandom);
			default: return 31'($urandom_range(0, 32'h0004_0000));
		endcase
	endfunction

	// Mostly a sphere that exists, sometimes the first one past the end or any index.
	function automatic logic [15:0] pick_index();
		int n;
		n = (scene_spheres < scbb_pkg::MAX_SPHERES) ? scene_spheres : scbb_pkg::MAX_SPHERES;
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return 16'(n);
			default: return (n == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom_range(0, n - 1));
		endcase
	endfunction

	task automatic issue_sphere();
		issue(scbb_pkg::CMD_ADD_SPHERE, rand_coord(), rand_coord(), rand_coord(), rand_rad(),
			16'($urandom), 16'($urandom));
	endtask

	task automatic issue_cylinder();
		issue(scbb_pkg::CMD_ADD_CYLINDER, $urandom, $urandom, $urandom, rand_rad(),
			pick_index(), pick_index());
	endtask

	// Random gap on the command side, none in the last stretch of the run.
	task automatic maybe_idle();
		if (idling && items < item_goal - CALM_ITEMS && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// Holds commands off until every outstanding query has returned its box.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (boxes_due != 0)
			@(posedge clk);
	endtask

	initial begin
		int scene;
		int fill;
		int wait_cycles;
		start = 1'b0;
		command = scbb_pkg::CMD_CLEAR;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		rad = '0;
		end_a_index = '0;
		end_b_index = '0;
		items = 0;
		scene_spheres = 0;
		idling = 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: empty scene, cylinders with no ends, saturation, boundary indices.
		issue_cmd(scbb_pkg::CMD_QUERY);
		issue(scbb_pkg::CMD_ADD_CYLINDER, 0, 0, 0, 31'd5, 16'd0, 16'd0);
		issue(scbb_pkg::CMD_ADD_CYLINDER, 0, 0, 0, 31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF);
		issue_cmd(scbb_pkg::CMD_QUERY);
		issue(scbb_pkg::CMD_ADD_SPHERE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 31'h7FFF_FFFF,
			16'd0, 16'd0);
		issue_cmd(scbb_pkg::CMD_QUERY);
		issue_cmd(scbb_pkg::CMD_CLEAR);
		issue_cmd(scbb_pkg::CMD_QUERY);
		issue(scbb_pkg::CMD_ADD_SPHERE, 32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000, 31'h8000,
			16'd0, 16'd0);
		issue(scbb_pkg::CMD_ADD_SPHERE, 32'hFFFB_0000, 32'h0004_0000, 32'h0, 31'd0,
			16'd0, 16'd0);
		issue(scbb_pkg::CMD_ADD_CYLINDER, 0, 0, 0, 31'h1_0000, 16'd0, 16'd1);
		issue(scbb_pkg::CMD_ADD_CYLINDER, 0, 0, 0, 31'h7FFF_FFFF, 16'd1, 16'd0);
		issue(scbb_pkg::CMD_ADD_CYLINDER, 0, 0, 0, 31'd1, 16'd2, 16'd0);
		issue(scbb_pkg::CMD_ADD_CYLINDER, 0, 0, 0, 31'd1, 16'd0, 16'hFFFF);
		issue_cmd(scbb_pkg::CMD_QUERY);
		issue(scbb_pkg::CMD_ADD_SPHERE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0,
			16'd0, 16'd0);
		issue(scbb_pkg::CMD_ADD_CYLINDER, 0, 0, 0, 31'h7FFF_FFFF, 16'd2, 16'd2);
		issue_cmd(scbb_pkg::CMD_QUERY);
		drain();
		issue_cmd(scbb_pkg::CMD_CLEAR);
		issue(scbb_pkg::CMD_ADD_SPHERE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'd1,
			16'd0, 16'd0);
		issue_cmd(scbb_pkg::CMD_QUERY);
		issue_cmd(scbb_pkg::CMD_CLEAR);

		// Random scenes: mostly small well-formed builds, a few filled past capacity.
		item_goal = items + RANDOM_ITEMS;
		scene = 0;
		while (items < item_goal) begin
			idling = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) != 0) begin
				maybe_idle();
				issue_cmd(scbb_pkg::CMD_CLEAR);
			end
			if (scene == 2 || scene == 5)
				fill = (scene == 2) ? 1 : 2;
			else if ($urandom_range(0, 29) == 0)
				fill = $urandom_range(1, 2);
			else
				fill = 0;
			case (fill)
				1: begin
					repeat (scbb_pkg::MAX_SPHERES + $urandom_range(1, 4)) begin
						maybe_idle();
						issue_sphere();
						if ($urandom_range(0, 39) == 0)
							issue_cmd(scbb_pkg::CMD_QUERY);
					end
				end
				2: begin
					repeat ($urandom_range(1, 4)) issue_sphere();
					repeat (scbb_pkg::MAX_CYLINDERS + $urandom_range(1, 4)) begin
						maybe_idle();
						issue_cylinder();
						if ($urandom_range(0, 39) == 0)
							issue_cmd(scbb_pkg::CMD_QUERY);
					end
				end
				default: begin
					repeat ($urandom_range(1, 24)) begin
						maybe_idle();
						case ($urandom_range(0, 19))
							0, 1, 2, 3, 4, 5, 6, 7, 8: issue_sphere();
							9, 10, 11, 12, 13, 14: issue_cylinder();
							15, 16, 17: issue_cmd(scbb_pkg::CMD_QUERY);
							18: issue_cmd(scbb_pkg::CMD_CLEAR);
							default: begin
								issue_cmd(scbb_pkg::CMD_QUERY);
								drain();
							end
						endcase
					end
				end
			endcase
			maybe_idle();
			issue_cmd(scbb_pkg::CMD_QUERY);
			// A clear after an overflow must also drop the sticky flag.
			if (fill != 0) begin
				issue_cmd(scbb_pkg::CMD_CLEAR);
				issue_cmd(scbb_pkg::CMD_QUERY);
			end
			scene++;
		end
		start <= 1'b0;

		// Let the last boxes arrive, then allow for any walk still in flight.
		wait_cycles = 0;
		while (boxes_due != 0 && wait_cycles < 5000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && boxes_due == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/scbb_pkg.sv
rtl/scbb_ram.sv
rtl/scbb_walk.sv
rtl/scbb_extent.sv
rtl/sphere_cylinder_bounding_box.sv
tb/sv/box_checker.sv
tb/sv/testbench.sv
